@@ sv/homogeneous_transform_apply_defines.svh @@
// ----------------------------------------------------------------------------
// homogeneous_transform_apply_defines.svh
// Assertion macros shared by the transform unit modules.
// ----------------------------------------------------------------------------
`ifndef HOMOGENEOUS_TRANSFORM_APPLY_DEFINES_SVH
`define HOMOGENEOUS_TRANSFORM_APPLY_DEFINES_SVH

// clocked assertion with explicit clock and reset
`define HTA_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked assertion on the block clock and reset
`define HTA_ASSERT(label, prop, msg) \
  `HTA_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

@@ sv/hta_pkg.sv @@
// ----------------------------------------------------------------------------
// hta_pkg
// Widths, item kinds and shared types of the homogeneous transform unit.
// ----------------------------------------------------------------------------
package hta_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int PROD_W     = 2 * WORD_WIDTH;
  localparam int ACC_W      = 2 * WORD_WIDTH + 2;
  localparam int NUM_W      = ACC_W + FRAC_BITS;
  localparam int QUO_W      = WORD_WIDTH + 1;
  localparam int DSH_W      = ACC_W + QUO_W;

  typedef logic signed [WORD_WIDTH-1:0] word_t;
  typedef logic signed [ACC_W-1:0]      acc_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};
  localparam word_t ONE_FIX  = word_t'(1) <<< FRAC_BITS;

  typedef enum logic [2:0] {
    KIND_LOAD_FWD = 3'd0,
    KIND_LOAD_INV = 3'd1,
    KIND_POINT    = 3'd2,
    KIND_VECTOR   = 3'd3,
    KIND_NORMAL   = 3'd4
  } kind_e;

  // control travelling with an item through the dot-product stages
  typedef struct packed {
    logic vld;
    logic point;
  } ctl_t;

  // finished result heading for the output register
  typedef struct packed {
    logic  vld;
    word_t x;
    word_t y;
    word_t z;
    logic  err;
    logic  sat;
  } res_t;

  // identity matrix entry, row-major
  function automatic word_t ident_entry(input int idx);
    return ((idx % 5) == 0) ? ONE_FIX : '0;
  endfunction

endpackage

@@ sv/hta_if.sv @@
// ----------------------------------------------------------------------------
// hta_in_if / hta_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface hta_in_if;
  logic           valid;
  logic           ready;
  logic [2:0]     kind;
  logic [3:0]     entry_index;
  hta_pkg::word_t entry_value;
  hta_pkg::word_t in_x;
  hta_pkg::word_t in_y;
  hta_pkg::word_t in_z;

  modport source (output valid, kind, entry_index, entry_value, in_x, in_y, in_z,
                  input ready);
  modport sink   (input valid, kind, entry_index, entry_value, in_x, in_y, in_z,
                  output ready);
endinterface

interface hta_out_if;
  logic           valid;
  logic           ready;
  hta_pkg::word_t out_x;
  hta_pkg::word_t out_y;
  hta_pkg::word_t out_z;
  logic           zero_w_error;
  logic           saturated;

  modport source (output valid, out_x, out_y, out_z, zero_w_error, saturated,
                  input ready);
  modport sink   (input valid, out_x, out_y, out_z, zero_w_error, saturated,
                  output ready);
endinterface

@@ sv/hta_coef_store.sv @@
// ----------------------------------------------------------------------------
// hta_coef_store
// Forward and inverse matrices, entry loads and per-item coefficient select.
// ----------------------------------------------------------------------------
`include "homogeneous_transform_apply_defines.svh"

module hta_coef_store (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           acc_i,
  input  logic [2:0]     kind_i,
  input  logic [3:0]     entry_index_i,
  input  hta_pkg::word_t entry_value_i,
  input  hta_pkg::word_t in_x_i,
  input  hta_pkg::word_t in_y_i,
  input  hta_pkg::word_t in_z_i,
  output hta_pkg::ctl_t  ctl_o,
  output hta_pkg::word_t coef_o [4][3],
  output hta_pkg::word_t trn_o [4],
  output hta_pkg::word_t p_o [3]
);
  import hta_pkg::*;

  word_t fwd_q [16];
  word_t inv_q [16];
  word_t coef_d [4][3];
  word_t trn_d [4];
  ctl_t  ctl_d;
  ctl_t  ctl_q;
  word_t coef_q [4][3];
  word_t trn_q [4];
  word_t p_q [3];

  // matrix entry loads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        fwd_q[i] <= ident_entry(i);
        inv_q[i] <= ident_entry(i);
      end
    end else if (acc_i) begin
      unique case (kind_i)
        KIND_LOAD_FWD: fwd_q[entry_index_i] <= entry_value_i;
        KIND_LOAD_INV: inv_q[entry_index_i] <= entry_value_i;
        default: ;
      endcase
    end
  end

  // coefficient select: normals take the transposed inverse
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int j = 0; j < 3; j++) begin
        coef_d[r][j] = (kind_i == KIND_NORMAL) ? inv_q[j*4+r] : fwd_q[r*4+j];
      end
      trn_d[r] = (kind_i == KIND_POINT) ? fwd_q[r*4+3] : '0;
    end
    ctl_d.vld   = acc_i && (kind_i == KIND_POINT || kind_i == KIND_VECTOR ||
                            kind_i == KIND_NORMAL);
    ctl_d.point = (kind_i == KIND_POINT);
  end

  // operand stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_d;
    end
  end

  // operand stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      coef_q <= coef_d;
      trn_q  <= trn_d;
      p_q[0] <= in_x_i;
      p_q[1] <= in_y_i;
      p_q[2] <= in_z_i;
    end
  end

  assign ctl_o  = ctl_q;
  assign coef_o = coef_q;
  assign trn_o  = trn_q;
  assign p_o    = p_q;

  `HTA_ASSERT(a_fwd_write, acc_i && kind_i == KIND_LOAD_FWD |=> fwd_q[$past(entry_index_i)] == $past(entry_value_i), "forward entry not written")

endmodule

@@ sv/hta_dot.sv @@
// ----------------------------------------------------------------------------
// hta_dot
// Twelve products in one stage, four row sums with translation in the next.
// ----------------------------------------------------------------------------
module hta_dot (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  hta_pkg::ctl_t  ctl_i,
  input  hta_pkg::word_t coef_i [4][3],
  input  hta_pkg::word_t trn_i [4],
  input  hta_pkg::word_t p_i [3],
  output hta_pkg::ctl_t  ctl_o,
  output hta_pkg::acc_t  acc_o [4]
);
  import hta_pkg::*;

  logic signed [PROD_W-1:0] prod_d [4][3];
  logic signed [PROD_W-1:0] prod_q [4][3];
  word_t trn_q [4];
  ctl_t  prd_ctl_q;
  ctl_t  sum_ctl_q;
  acc_t  acc_d [4];
  acc_t  acc_q [4];

  // products
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d[r][j] = PROD_W'(coef_i[r][j]) * PROD_W'(p_i[j]);
      end
    end
  end

  // row sums, translation aligned to product scale
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      acc_d[r] = ACC_W'(prod_q[r][0]) + ACC_W'(prod_q[r][1]) + ACC_W'(prod_q[r][2]) +
                 (ACC_W'(trn_q[r]) <<< FRAC_BITS);
    end
  end

  // stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prd_ctl_q <= '0;
      sum_ctl_q <= '0;
    end else if (en_i) begin
      prd_ctl_q <= ctl_i;
      sum_ctl_q <= prd_ctl_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      trn_q  <= trn_i;
      acc_q  <= acc_d;
    end
  end

  assign ctl_o = sum_ctl_q;
  assign acc_o = acc_q;

endmodule

@@ sv/hta_divide.sv @@
// ----------------------------------------------------------------------------
// hta_divide
// Homogeneous divide: magnitude set-up, overflow check, one quotient bit per
// stage for three lanes, then sign, saturation and result select.
// ----------------------------------------------------------------------------
`include "homogeneous_transform_apply_defines.svh"

module hta_divide (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  hta_pkg::ctl_t ctl_i,
  input  hta_pkg::acc_t acc_i [4],
  output hta_pkg::res_t res_o
);
  import hta_pkg::*;

  typedef struct packed {
    logic vld;
    logic wzero;
    logic divide;
  } dctl_t;

  localparam acc_t W_ONE = acc_t'(1) <<< (2 * FRAC_BITS);

  // set-up stage
  dctl_t             nrm_ctl_d;
  dctl_t             nrm_ctl_q;
  logic [NUM_W-1:0]  nrm_num_d [3];
  logic [NUM_W-1:0]  nrm_num_q [3];
  logic              nrm_neg_d [3];
  logic              nrm_neg_q [3];
  logic [ACC_W-1:0]  nrm_den_d;
  logic [ACC_W-1:0]  nrm_den_q;
  acc_t              nrm_dir_d [3];
  acc_t              nrm_dir_q [3];
  logic [ACC_W-1:0]  mag [3];

  // divider chain, entry 0 is the check stage
  dctl_t             div_ctl_q [QUO_W+1];
  logic [NUM_W-1:0]  div_rem_q [QUO_W+1][3];
  logic [QUO_W-1:0]  div_quo_q [QUO_W+1][3];
  logic [ACC_W-1:0]  div_den_q [QUO_W+1];
  logic              div_neg_q [QUO_W+1][3];
  logic              div_ovf_q [QUO_W+1][3];
  word_t             div_dres_q [QUO_W+1][3];
  logic              div_dsat_q [QUO_W+1][3];

  logic              chk_ovf [3];
  word_t             chk_dres [3];
  logic              chk_dsat [3];

  word_t             fin_val [3];
  logic              fin_sat [3];
  logic [QUO_W-1:0]  q_last;

  // magnitudes, signs and the plain rescale
  always_comb begin
    nrm_ctl_d.vld    = ctl_i.vld;
    nrm_ctl_d.wzero  = ctl_i.point && (acc_i[3] == '0);
    nrm_ctl_d.divide = ctl_i.point && (acc_i[3] != '0) && (acc_i[3] != W_ONE);
    nrm_den_d = acc_i[3][ACC_W-1] ? ACC_W'(-acc_i[3]) : ACC_W'(acc_i[3]);
    for (int l = 0; l < 3; l++) begin
      mag[l]       = acc_i[l][ACC_W-1] ? ACC_W'(-acc_i[l]) : ACC_W'(acc_i[l]);
      nrm_num_d[l] = {mag[l], {FRAC_BITS{1'b0}}};
      nrm_neg_d[l] = acc_i[l][ACC_W-1] ^ acc_i[3][ACC_W-1];
      nrm_dir_d[l] = acc_i[l] >>> FRAC_BITS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nrm_ctl_q <= '0;
    end else if (en_i) begin
      nrm_ctl_q <= nrm_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nrm_num_q <= nrm_num_d;
      nrm_neg_q <= nrm_neg_d;
      nrm_den_q <= nrm_den_d;
      nrm_dir_q <= nrm_dir_d;
    end
  end

  // quotient overflow check and clamp of the plain rescale
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      chk_ovf[l] = DSH_W'(nrm_num_q[l]) >= (DSH_W'(nrm_den_q) << QUO_W);
      if (nrm_dir_q[l] > ACC_W'(WORD_MAX)) begin
        chk_dres[l] = WORD_MAX;
        chk_dsat[l] = 1'b1;
      end else if (nrm_dir_q[l] < ACC_W'(WORD_MIN)) begin
        chk_dres[l] = WORD_MIN;
        chk_dsat[l] = 1'b1;
      end else begin
        chk_dres[l] = WORD_WIDTH'(nrm_dir_q[l]);
        chk_dsat[l] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_ctl_q[0] <= '0;
    end else if (en_i) begin
      div_ctl_q[0] <= nrm_ctl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_den_q[0] <= nrm_den_q;
      for (int l = 0; l < 3; l++) begin
        div_rem_q[0][l]  <= nrm_num_q[l];
        div_quo_q[0][l]  <= '0;
        div_neg_q[0][l]  <= nrm_neg_q[l];
        div_ovf_q[0][l]  <= chk_ovf[l];
        div_dres_q[0][l] <= chk_dres[l];
        div_dsat_q[0][l] <= chk_dsat[l];
      end
    end
  end

  // restoring division, most significant quotient bit first
  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    localparam int BIT = QUO_W - 1 - k;
    logic [DSH_W-1:0] sub [3];
    logic             take [3];

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        sub[l]  = DSH_W'(div_rem_q[k][l]) - (DSH_W'(div_den_q[k]) << BIT);
        take[l] = DSH_W'(div_rem_q[k][l]) >= (DSH_W'(div_den_q[k]) << BIT);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_ctl_q[k+1] <= '0;
      end else if (en_i) begin
        div_ctl_q[k+1] <= div_ctl_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        div_den_q[k+1] <= div_den_q[k];
        for (int l = 0; l < 3; l++) begin
          div_rem_q[k+1][l]  <= take[l] ? NUM_W'(sub[l]) : div_rem_q[k][l];
          div_quo_q[k+1][l]  <= div_quo_q[k][l] | (QUO_W'(take[l]) << BIT);
          div_neg_q[k+1][l]  <= div_neg_q[k][l];
          div_ovf_q[k+1][l]  <= div_ovf_q[k][l];
          div_dres_q[k+1][l] <= div_dres_q[k][l];
          div_dsat_q[k+1][l] <= div_dsat_q[k][l];
        end
      end
    end
  end

  // quotient sign and saturation
  always_comb begin
    q_last = '0;
    for (int l = 0; l < 3; l++) begin
      q_last = div_quo_q[QUO_W][l];
      if (div_ovf_q[QUO_W][l]) begin
        fin_val[l] = div_neg_q[QUO_W][l] ? WORD_MIN : WORD_MAX;
        fin_sat[l] = 1'b1;
      end else if (div_neg_q[QUO_W][l]) begin
        if (q_last > (QUO_W'(1) << (WORD_WIDTH - 1))) begin
          fin_val[l] = WORD_MIN;
          fin_sat[l] = 1'b1;
        end else begin
          fin_val[l] = WORD_WIDTH'(~q_last + QUO_W'(1));
          fin_sat[l] = 1'b0;
        end
      end else if (q_last > QUO_W'($unsigned(WORD_MAX))) begin
        fin_val[l] = WORD_MAX;
        fin_sat[l] = 1'b1;
      end else begin
        fin_val[l] = WORD_WIDTH'(q_last);
        fin_sat[l] = 1'b0;
      end
    end
  end

  // result select
  always_comb begin
    res_o.vld = div_ctl_q[QUO_W].vld;
    if (div_ctl_q[QUO_W].wzero) begin
      res_o.x   = '0;
      res_o.y   = '0;
      res_o.z   = '0;
      res_o.err = 1'b1;
      res_o.sat = 1'b0;
    end else if (div_ctl_q[QUO_W].divide) begin
      res_o.x   = fin_val[0];
      res_o.y   = fin_val[1];
      res_o.z   = fin_val[2];
      res_o.err = 1'b0;
      res_o.sat = fin_sat[0] | fin_sat[1] | fin_sat[2];
    end else begin
      res_o.x   = div_dres_q[QUO_W][0];
      res_o.y   = div_dres_q[QUO_W][1];
      res_o.z   = div_dres_q[QUO_W][2];
      res_o.err = 1'b0;
      res_o.sat = div_dsat_q[QUO_W][0] | div_dsat_q[QUO_W][1] | div_dsat_q[QUO_W][2];
    end
  end

  `HTA_ASSERT(a_rem_below_den, div_ctl_q[QUO_W].vld && div_ctl_q[QUO_W].divide && !div_ovf_q[QUO_W][0] |-> div_rem_q[QUO_W][0] < div_den_q[QUO_W], "remainder not below divisor")
  `HTA_ASSERT(a_div_flags, div_ctl_q[QUO_W].vld |-> !(div_ctl_q[QUO_W].wzero && div_ctl_q[QUO_W].divide), "zero w item marked for division")

endmodule

@@ sv/homogeneous_transform_apply.sv @@
// ----------------------------------------------------------------------------
// homogeneous_transform_apply
// Applies a stored 4x4 Q16.16 transform to points, vectors and normals.
// ----------------------------------------------------------------------------
// Takes one item per clock unless the pipeline holds, and presents each point,
// vector or normal result after it has passed 39 registers: one
// operand stage, one product stage, one sum stage, two divide set-up stages,
// 33 divide stages (one quotient bit each) and the output register. Loads
// write their entry on acceptance and give no result; an item is transformed
// with the matrices as they stand when it is accepted. While a result waits
// at the output the whole pipeline holds, and ready drops until the result
// is taken.

module homogeneous_transform_apply (
  input logic    clk_i,
  input logic    rst_ni,
  hta_in_if.sink    item_i,
  hta_out_if.source result_o
);
  import hta_pkg::*;

  logic  en;
  logic  acc;
  ctl_t  opd_ctl;
  word_t coef [4][3];
  word_t trn [4];
  word_t pnt [3];
  ctl_t  sum_ctl;
  acc_t  sums [4];
  res_t  res;
  logic  out_vld_q;
  word_t out_x_q;
  word_t out_y_q;
  word_t out_z_q;
  logic  out_err_q;
  logic  out_sat_q;

  // pipeline advances unless a result is held at the output
  assign en           = !out_vld_q || result_o.ready;
  assign item_i.ready = en;
  assign acc          = item_i.valid && en;

  hta_coef_store u_store (
    .clk_i,
    .rst_ni,
    .en_i          (en),
    .acc_i         (acc),
    .kind_i        (item_i.kind),
    .entry_index_i (item_i.entry_index),
    .entry_value_i (item_i.entry_value),
    .in_x_i        (item_i.in_x),
    .in_y_i        (item_i.in_y),
    .in_z_i        (item_i.in_z),
    .ctl_o         (opd_ctl),
    .coef_o        (coef),
    .trn_o         (trn),
    .p_o           (pnt)
  );

  hta_dot u_dot (
    .clk_i,
    .rst_ni,
    .en_i   (en),
    .ctl_i  (opd_ctl),
    .coef_i (coef),
    .trn_i  (trn),
    .p_i    (pnt),
    .ctl_o  (sum_ctl),
    .acc_o  (sums)
  );

  hta_divide u_div (
    .clk_i,
    .rst_ni,
    .en_i  (en),
    .ctl_i (sum_ctl),
    .acc_i (sums),
    .res_o (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= res.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_x_q   <= res.x;
      out_y_q   <= res.y;
      out_z_q   <= res.z;
      out_err_q <= res.err;
      out_sat_q <= res.sat;
    end
  end

  assign result_o.valid        = out_vld_q;
  assign result_o.out_x        = out_x_q;
  assign result_o.out_y        = out_y_q;
  assign result_o.out_z        = out_z_q;
  assign result_o.zero_w_error = out_err_q;
  assign result_o.saturated    = out_sat_q;

  `HTA_ASSERT(a_zero_w_clean, out_vld_q && out_err_q |-> out_x_q == '0 && out_y_q == '0 && out_z_q == '0 && !out_sat_q, "zero w result not cleared")

endmodule

@@ test/tb_homogeneous_transform_apply.sv @@
// ----------------------------------------------------------------------------
// tb_homogeneous_transform_apply
// Self-checking bench for the homogeneous transform unit: directed rows
// followed by random matrices and points, vectors and normals, with random
// idling on both channels and a built-in transform predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_homogeneous_transform_apply;
  import hta_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;

  // one input item and one result item
  typedef struct {
    logic [2:0] kind;
    logic [3:0] idx;
    word_t      val;
    word_t      x, y, z;
  } item_t;

  typedef struct packed {
    word_t x, y, z;
    logic  err, sat;
  } xform_res_t;

  // directed row: item plus an optional typed-in expectation
  typedef struct {
    item_t      it;
    logic       fixed;
    xform_res_t res;
  } row_t;

  logic clk_i, rst_ni;
  hta_in_if  item_if ();
  hta_out_if res_if ();

  homogeneous_transform_apply i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if.sink),
    .result_o(res_if.source)
  );

  // clock
  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  word_t fwd_m [16];
  word_t inv_m [16];
  xform_res_t pending_q[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // saturate a wide value to the word range
  function automatic word_t clamp_word(input logic signed [159:0] v, inout logic sat);
    if (v > 160'(signed'(WORD_MAX))) begin
      sat = 1'b1;
      return WORD_MAX;
    end
    if (v < 160'(signed'(WORD_MIN))) begin
      sat = 1'b1;
      return WORD_MIN;
    end
    return v[31:0];
  endfunction

  // transform one item against the current matrices
  function automatic xform_res_t transform(input item_t it);
    xform_res_t r;
    logic signed [159:0] acc [4];
    logic signed [159:0] v, num, q;
    word_t p [3];
    logic divide;
    r = '{default: '0};
    p[0] = it.x; p[1] = it.y; p[2] = it.z;
    for (int row = 0; row < 4; row++) begin
      acc[row] = '0;
      for (int j = 0; j < 3; j++) begin
        if (it.kind == KIND_NORMAL)
          acc[row] += 160'(inv_m[j*4+row]) * 160'(p[j]);
        else
          acc[row] += 160'(fwd_m[row*4+j]) * 160'(p[j]);
      end
      if (it.kind == KIND_POINT) acc[row] += 160'(fwd_m[row*4+3]) <<< FRAC_BITS;
    end
    if (it.kind == KIND_POINT && acc[3] == 0) begin
      r.err = 1'b1;
      return r;
    end
    divide = (it.kind == KIND_POINT) && (acc[3] != (160'sd1 <<< (2*FRAC_BITS)));
    for (int c = 0; c < 3; c++) begin
      if (divide) begin
        num = acc[c] <<< FRAC_BITS;
        q = num / acc[3];
        v = q;
      end else begin
        v = acc[c] >>> FRAC_BITS;
      end
      case (c)
        0: r.x = clamp_word(v, r.sat);
        1: r.y = clamp_word(v, r.sat);
        default: r.z = clamp_word(v, r.sat);
      endcase
    end
    return r;
  endfunction

  // predictor update on acceptance
  function automatic void accept_item(input item_t it, input logic fixed,
                                      input xform_res_t fixed_res);
    xform_res_t r;
    case (it.kind)
      KIND_LOAD_FWD: fwd_m[it.idx] = it.val;
      KIND_LOAD_INV: inv_m[it.idx] = it.val;
      KIND_POINT, KIND_VECTOR, KIND_NORMAL: begin
        r = transform(it);
        if (fixed && r != fixed_res) begin
          $display("%0t table row disagrees with predictor", $time);
          errors++;
        end
        pending_q.push_back(fixed ? fixed_res : r);
      end
      default: ;
    endcase
  endfunction

  // drive one item and wait for its handshake
  task automatic send_item(input item_t it, input logic fixed = 1'b0,
                           input xform_res_t fres = '{default: '0});
    while ($urandom_range(99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_if.valid       <= 1'b1;
    item_if.kind        <= it.kind;
    item_if.entry_index <= it.idx;
    item_if.entry_value <= it.val;
    item_if.in_x        <= it.x;
    item_if.in_y        <= it.y;
    item_if.in_z        <= it.z;
    do @(posedge clk_i); while (!item_if.ready);
    accept_item(it, fixed, fres);
  endtask

  // result checking
  always @(posedge clk_i) begin
    xform_res_t e;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        if (pending_q.size() == 0) begin
          $display("%0t unexpected result x=%h y=%h z=%h", $time,
                   res_if.out_x, res_if.out_y, res_if.out_z);
          errors++;
        end else begin
          e = pending_q.pop_front();
          if (res_if.out_x !== e.x || res_if.out_y !== e.y || res_if.out_z !== e.z ||
              res_if.zero_w_error !== e.err || res_if.saturated !== e.sat) begin
            $display("%0t mismatch expected x=%h y=%h z=%h err=%b sat=%b", $time,
                     e.x, e.y, e.z, e.err, e.sat);
            $display("%0t          actual   x=%h y=%h z=%h err=%b sat=%b", $time,
                     res_if.out_x, res_if.out_y, res_if.out_z,
                     res_if.zero_w_error, res_if.saturated);
            errors++;
          end
        end
      end
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic word_t rand_word();
    case ($urandom_range(7))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return word_t'($urandom_range(8)) <<< FRAC_BITS;
      3: return -(word_t'($urandom_range(8)) <<< FRAC_BITS);
      4, 5: return word_t'(int'($urandom_range(262144)) - 131072);
      default: return $urandom();
    endcase
  endfunction

  function automatic item_t rand_item();
    item_t it;
    int sel;
    sel = $urandom_range(99);
    it.idx = $urandom_range(15);
    it.val = rand_word();
    it.x = rand_word();
    it.y = rand_word();
    it.z = rand_word();
    if (sel < 8)       it.kind = KIND_LOAD_FWD;
    else if (sel < 14) it.kind = KIND_LOAD_INV;
    else if (sel < 52) it.kind = KIND_POINT;
    else if (sel < 72) it.kind = KIND_VECTOR;
    else if (sel < 97) it.kind = KIND_NORMAL;
    else               it.kind = 3'($urandom_range(7, 5));
    // steer the bottom row so w of one and w of zero both turn up
    if (it.kind == KIND_LOAD_FWD && $urandom_range(3) == 0) begin
      it.idx = 4'($urandom_range(15, 12));
      it.val = (it.idx == 15) ? ONE_FIX : '0;
    end
    return it;
  endfunction

  row_t rows [$];
  xform_res_t zr, wz;
  item_t it;

  initial begin
    rst_ni = 1'b0;
    item_if.valid = 1'b0;
    item_if.kind = '0;
    item_if.entry_index = '0;
    item_if.entry_value = '0;
    item_if.in_x = '0;
    item_if.in_y = '0;
    item_if.in_z = '0;
    res_if.ready = 1'b0;
    for (int i = 0; i < 16; i++) begin
      fwd_m[i] = ident_entry(i);
      inv_m[i] = ident_entry(i);
    end
    zr = '{default: '0};
    wz = '{default: '0};
    wz.err = 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: identity pass-through, extremes, zero w, overflow
    rows = '{
      '{'{KIND_POINT,  4'd0, '0, WORD_MAX, WORD_MIN, 32'sd0}, 1'b1,
        '{WORD_MAX, WORD_MIN, 32'sd0, 1'b0, 1'b0}},
      '{'{KIND_VECTOR, 4'd0, '0, WORD_MIN, WORD_MAX, -32'sd1}, 1'b1,
        '{WORD_MIN, WORD_MAX, -32'sd1, 1'b0, 1'b0}},
      '{'{KIND_NORMAL, 4'd0, '0, 32'sd1, -32'sd1, ONE_FIX}, 1'b1,
        '{32'sd1, -32'sd1, ONE_FIX, 1'b0, 1'b0}},
      '{'{3'd5, 4'd0, '0, '0, '0, '0}, 1'b0, zr},
      '{'{3'd7, 4'd15, WORD_MIN, '0, '0, '0}, 1'b0, zr},
      '{'{KIND_LOAD_FWD, 4'd0, WORD_MAX, '0, '0, '0}, 1'b0, zr},
      '{'{KIND_VECTOR, 4'd0, '0, WORD_MAX, '0, '0}, 1'b1,
        '{WORD_MAX, 32'sd0, 32'sd0, 1'b0, 1'b1}},
      '{'{KIND_LOAD_FWD, 4'd0, WORD_MIN, '0, '0, '0}, 1'b0, zr},
      '{'{KIND_VECTOR, 4'd0, '0, WORD_MIN, '0, '0}, 1'b1,
        '{WORD_MAX, 32'sd0, 32'sd0, 1'b0, 1'b1}},
      '{'{KIND_LOAD_FWD, 4'd15, '0, '0, '0, '0}, 1'b0, zr},
      '{'{KIND_POINT, 4'd0, '0, WORD_MAX, WORD_MAX, WORD_MAX}, 1'b1, wz},
      '{'{KIND_LOAD_FWD, 4'd15, ONE_FIX <<< 1, '0, '0, '0}, 1'b0, zr},
      '{'{KIND_LOAD_FWD, 4'd0, ONE_FIX, '0, '0, '0}, 1'b0, zr},
      '{'{KIND_LOAD_FWD, 4'd3, -ONE_FIX, '0, '0, '0}, 1'b0, zr},
      '{'{KIND_POINT, 4'd0, '0, 32'sd7, -32'sd5, WORD_MIN}, 1'b0, zr},
      '{'{KIND_LOAD_FWD, 4'd15, -ONE_FIX, '0, '0, '0}, 1'b0, zr},
      '{'{KIND_POINT, 4'd0, '0, WORD_MAX, 32'sd3, -32'sd3}, 1'b0, zr},
      '{'{KIND_LOAD_INV, 4'd1, WORD_MAX, '0, '0, '0}, 1'b0, zr},
      '{'{KIND_LOAD_INV, 4'd14, WORD_MIN, '0, '0, '0}, 1'b0, zr},
      '{'{KIND_NORMAL, 4'd0, '0, WORD_MAX, WORD_MIN, WORD_MAX}, 1'b0, zr},
      '{'{KIND_VECTOR, 4'd0, '0, -32'sd1, -32'sd1, -32'sd1}, 1'b0, zr}
    };
    foreach (rows[i]) send_item(rows[i].it, rows[i].fixed, rows[i].res);

    // random part in four idling phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      for (int n = 0; n < 212; n++) begin
        it = rand_item();
        send_item(it);
      end
    end
    item_if.valid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
